### src/mdd_pkg.sv
// ----------------------------------------------------------------------------
// Morse duration decoder package
// Shared types, register indexes, limits and the code tree lookup.
// ----------------------------------------------------------------------------
package mdd_pkg;

   localparam int DURATION_W      = 16;
   localparam int DURATION_BITS   = 16;
   localparam int MAX_CODE_LENGTH = 5;
   localparam int TREE_DEPTH      = 5;
   localparam int POS_W           = 6;
   localparam int CHAR_W          = 7;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QCOUNT_W        = $clog2(QUEUE_DEPTH + 1);

   // Saturation limit of an incoming duration.
   localparam logic [DURATION_W-1:0] DUR_MAX = (DURATION_BITS >= DURATION_W) ?
      {DURATION_W{1'b1}} : DURATION_W'((64'd1 << DURATION_BITS) - 64'd1);

   // First heap index whose depth reaches the code length limit.
   localparam int CODE_LIMIT = (MAX_CODE_LENGTH < TREE_DEPTH) ? MAX_CODE_LENGTH
                                                              : TREE_DEPTH;
   localparam logic [POS_W-1:0] OVERFLOW_POS = POS_W'((1 << CODE_LIMIT) - 1);

   localparam logic [DURATION_W-1:0] DASH_RESET = 16'd600;
   localparam logic [DURATION_W-1:0] WORD_RESET = 16'd1400;
   localparam logic [DURATION_W-1:0] STOP_RESET = 16'd4200;

   localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'd0;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'd32;

   typedef enum logic [1:0] {
      REG_DASH_THRESHOLD = 2'd0,
      REG_WORD_THRESHOLD = 2'd1,
      REG_STOP_THRESHOLD = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [DURATION_W-1:0] duration;
      logic                  is_mark;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              message_end;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [DURATION_W-1:0] dash_threshold;
      logic [DURATION_W-1:0] word_gap_threshold;
      logic [DURATION_W-1:0] stop_threshold;
   } cfg_type;

   typedef struct packed {
      logic [POS_W-1:0] position;
      logic             overflow;
   } letter_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
      letter_type letter;
   } step_type;

   // Heap-ordered code tree: dot child of p is 2p+1, dash child is 2p+2.
   function automatic logic [CHAR_W-1:0] tree_char(input logic [POS_W-1:0] p);
      logic [CHAR_W-1:0] c;
      case (p)
         6'd1:    c = 7'("E");
         6'd2:    c = 7'("T");
         6'd3:    c = 7'("I");
         6'd4:    c = 7'("A");
         6'd5:    c = 7'("N");
         6'd6:    c = 7'("M");
         6'd7:    c = 7'("S");
         6'd8:    c = 7'("U");
         6'd9:    c = 7'("R");
         6'd10:   c = 7'("W");
         6'd11:   c = 7'("D");
         6'd12:   c = 7'("K");
         6'd13:   c = 7'("G");
         6'd14:   c = 7'("O");
         6'd15:   c = 7'("H");
         6'd16:   c = 7'("V");
         6'd17:   c = 7'("F");
         6'd19:   c = 7'("L");
         6'd21:   c = 7'("P");
         6'd22:   c = 7'("J");
         6'd23:   c = 7'("B");
         6'd24:   c = 7'("X");
         6'd25:   c = 7'("C");
         6'd26:   c = 7'("Y");
         6'd27:   c = 7'("Z");
         6'd28:   c = 7'("Q");
         6'd31:   c = 7'("5");
         6'd32:   c = 7'("4");
         6'd34:   c = 7'("3");
         6'd38:   c = 7'("2");
         6'd46:   c = 7'("1");
         6'd47:   c = 7'("6");
         6'd55:   c = 7'("7");
         6'd59:   c = 7'("8");
         6'd61:   c = 7'("9");
         6'd62:   c = 7'("0");
         default: c = CHAR_NONE;
      endcase
      return c;
   endfunction

endpackage

### src/morse_duration_decoder.sv
// ----------------------------------------------------------------------------
// Morse duration decoder
// Turns timed marks and gaps into letters, digits, word spaces and an end
// of message flag.
//
//   Channel   Ports                             Direction   Moves
//   req       req_valid/req_ready/req_item      in          one duration
//   rsp       rsp_valid/rsp_ready/rsp_item      out         one character
//   csr       csr_write_en/csr_index/csr_wdata  in          threshold write
//
// A request is registered, then decoded combinationally into 0 to 2 responses
// that enter a 4-entry response queue; the responses are registered in the
// queue before the first can be taken. One
// request per cycle is sustained while the consumer keeps up; the decode
// stage waits while fewer than two queue entries are free. Reset is
// synchronous: thresholds return to 600, 1400 and 4200, the letter state
// returns to the tree root and the queue empties.
// ----------------------------------------------------------------------------
module morse_duration_decoder (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  mdd_pkg::req_type                 req_item,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output mdd_pkg::rsp_type                 rsp_item,
   input  logic                             csr_write_en,
   input  logic [1:0]                       csr_index,
   input  logic [mdd_pkg::DURATION_W-1:0]   csr_wdata
);

   logic                         stage_valid_ff;
   logic                         stage_valid_in;
   mdd_pkg::req_type             stage_item_ff;
   mdd_pkg::letter_type          letter_ff;
   mdd_pkg::letter_type          letter_in;
   mdd_pkg::cfg_type             cfg_ff;
   mdd_pkg::cfg_type             cfg_in;
   mdd_pkg::step_type            step;
   logic                         stage_fire;
   logic                         req_accept;
   logic [mdd_pkg::QCOUNT_W-1:0] q_count;

   assign stage_fire = stage_valid_ff &&
                       (q_count <= mdd_pkg::QCOUNT_W'(mdd_pkg::QUEUE_DEPTH - 2));
   assign req_ready  = !stage_valid_ff || stage_fire;
   assign req_accept = req_valid && req_ready;

   assign stage_valid_in = req_accept ? 1'b1 : (stage_fire ? 1'b0 : stage_valid_ff);
   assign letter_in      = stage_fire ? step.letter : letter_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            mdd_pkg::REG_DASH_THRESHOLD: cfg_in.dash_threshold     = csr_wdata;
            mdd_pkg::REG_WORD_THRESHOLD: cfg_in.word_gap_threshold = csr_wdata;
            mdd_pkg::REG_STOP_THRESHOLD: cfg_in.stop_threshold     = csr_wdata;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff            <= 1'b0;
         letter_ff                 <= '0;
         cfg_ff.dash_threshold     <= mdd_pkg::DASH_RESET;
         cfg_ff.word_gap_threshold <= mdd_pkg::WORD_RESET;
         cfg_ff.stop_threshold     <= mdd_pkg::STOP_RESET;
      end else begin
         stage_valid_ff <= stage_valid_in;
         letter_ff      <= letter_in;
         cfg_ff         <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_item_ff <= req_item;
      end
   end

   mdd_step u_step (
      .item   (stage_item_ff),
      .cfg    (cfg_ff),
      .letter (letter_ff),
      .step   (step)
   );

   mdd_rsp_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_count  (stage_fire ? step.count : 2'd0),
      .push_first  (step.first),
      .push_second (step.second),
      .pop         (rsp_ready),
      .head        (rsp_item),
      .head_valid  (rsp_valid),
      .count       (q_count)
   );

   // queue never overfills
   assert property (@(posedge clock) disable iff (reset)
      q_count <= mdd_pkg::QCOUNT_W'(mdd_pkg::QUEUE_DEPTH))
      else $error("response queue overflow");

   // the code walk stays inside the tree
   assert property (@(posedge clock) disable iff (reset)
      letter_ff.position != {mdd_pkg::POS_W{1'b1}})
      else $error("tree position out of range");

   // every emitted response closes the current letter
   assert property (@(posedge clock) disable iff (reset)
      stage_fire && (step.count != 2'd0) |=> (letter_ff == '0))
      else $error("letter state not cleared after output");

   // a decode only fires with room for two responses
   assert property (@(posedge clock) disable iff (reset)
      stage_fire |=> (q_count <= mdd_pkg::QCOUNT_W'(mdd_pkg::QUEUE_DEPTH)))
      else $error("decode fired without queue room");

endmodule

### src/mdd_step.sv
// ----------------------------------------------------------------------------
// Morse duration decoder step
// Classifies one duration and advances the letter state; forms up to two
// results.
// ----------------------------------------------------------------------------
module mdd_step (
   input  mdd_pkg::req_type    item,
   input  mdd_pkg::cfg_type    cfg,
   input  mdd_pkg::letter_type letter,
   output mdd_pkg::step_type   step
);

   logic [mdd_pkg::DURATION_W-1:0] dur;
   logic [mdd_pkg::CHAR_W-1:0]     pending;
   logic                           has_char;
   logic                           has_space;
   mdd_pkg::rsp_type               char_rsp;
   mdd_pkg::rsp_type               space_rsp;

   assign dur = (item.duration > mdd_pkg::DUR_MAX) ? mdd_pkg::DUR_MAX : item.duration;
   assign pending = letter.overflow ? mdd_pkg::CHAR_NONE : mdd_pkg::tree_char(letter.position);
   assign has_char  = (pending != mdd_pkg::CHAR_NONE);
   assign has_space = (dur > cfg.word_gap_threshold);

   always_comb begin
      char_rsp             = '0;
      char_rsp.character   = pending;
      char_rsp.last        = !has_space;
      space_rsp            = '0;
      space_rsp.character  = mdd_pkg::CHAR_SPACE;
      space_rsp.last       = 1'b1;

      step        = '0;
      step.letter = letter;

      if (dur == '0) begin
         // drop zero durations
         step.count = 2'd0;
      end else if (dur >= cfg.stop_threshold) begin
         step.count              = 2'd1;
         step.first.character    = pending;
         step.first.message_end  = 1'b1;
         step.first.last         = 1'b1;
         step.letter             = '0;
      end else if (item.is_mark) begin
         if (!letter.overflow) begin
            if (letter.position >= mdd_pkg::OVERFLOW_POS) begin
               step.letter.overflow = 1'b1;
            end else begin
               step.letter.position = {letter.position[mdd_pkg::POS_W-2:0], 1'b0} +
                  ((dur >= cfg.dash_threshold) ? mdd_pkg::POS_W'(2) : mdd_pkg::POS_W'(1));
            end
         end
      end else if (dur >= cfg.dash_threshold) begin
         step.count  = 2'({1'b0, has_char}) + 2'({1'b0, has_space});
         step.first  = has_char ? char_rsp : space_rsp;
         step.second = space_rsp;
         step.letter = '0;
      end
   end

endmodule

### src/mdd_rsp_queue.sv
// ----------------------------------------------------------------------------
// Morse duration decoder response queue
// Small shift queue: takes up to two responses per cycle, hands out one.
// ----------------------------------------------------------------------------
module mdd_rsp_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [1:0]                     push_count,
   input  mdd_pkg::rsp_type               push_first,
   input  mdd_pkg::rsp_type               push_second,
   input  logic                           pop,
   output mdd_pkg::rsp_type               head,
   output logic                           head_valid,
   output logic [mdd_pkg::QCOUNT_W-1:0]   count
);

   mdd_pkg::rsp_type                slot_ff [mdd_pkg::QUEUE_DEPTH];
   mdd_pkg::rsp_type                slot_in [mdd_pkg::QUEUE_DEPTH];
   logic [mdd_pkg::QCOUNT_W-1:0]    count_ff;
   logic [mdd_pkg::QCOUNT_W-1:0]    count_in;
   logic [mdd_pkg::QCOUNT_W-1:0]    base;
   logic                            do_pop;

   assign do_pop   = pop && (count_ff != '0);
   assign base     = count_ff - mdd_pkg::QCOUNT_W'(do_pop);
   assign count_in = base + mdd_pkg::QCOUNT_W'(push_count);

   always_comb begin
      for (int i = 0; i < mdd_pkg::QUEUE_DEPTH; i++) begin
         // advance toward the head on a pop
         if (do_pop && (i + 1 < mdd_pkg::QUEUE_DEPTH)) begin
            slot_in[i] = slot_ff[i + 1];
         end else begin
            slot_in[i] = slot_ff[i];
         end
         if ((push_count != 2'd0) && (mdd_pkg::QCOUNT_W'(i) == base)) begin
            slot_in[i] = push_first;
         end
         if ((push_count == 2'd2) && (mdd_pkg::QCOUNT_W'(i) == base + 1'b1)) begin
            slot_in[i] = push_second;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < mdd_pkg::QUEUE_DEPTH; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

   assign head       = slot_ff[0];
   assign head_valid = (count_ff != '0);
   assign count      = count_ff;

endmodule
